// File: rtl/mrrt_pkg.sv
// Shared types, codes and the CRC-16 byte step for the Modbus RTU read transaction block.
package mrrt_pkg;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int QTY_W    = 7;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    // Largest register count that goes out in a request
    localparam logic [QTY_W-1:0] MAX_QUANTITY = 7'd125;
    // Fixed response bytes around the register data
    localparam logic [7:0]       HDR_LEN      = 8'd5;
    localparam logic [15:0]      CRC_INIT     = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY     = 16'hA001;

    // Input item kinds
    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RX    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ABORT = 2'd2;

    // Result item kinds
    localparam logic OUT_TX   = 1'b0;
    localparam logic OUT_DONE = 1'b1;

    // Completion status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CRC_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;

    // Request byte positions after the slave id
    localparam logic [2:0] REQ_FUNC    = 3'd1;
    localparam logic [2:0] REQ_ADDR_HI = 3'd2;
    localparam logic [2:0] REQ_ADDR_LO = 3'd3;
    localparam logic [2:0] REQ_QTY_HI  = 3'd4;
    localparam logic [2:0] REQ_QTY_LO  = 3'd5;
    localparam logic [2:0] REQ_CRC_LO  = 3'd6;
    localparam logic [2:0] REQ_CRC_HI  = 3'd7;

    // One input item, unpacked
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        slave_id;
        logic [7:0]        function_code;
        logic [15:0]       start_address;
        logic [QTY_W-1:0]  quantity;
        logic              want_float;
        logic [7:0]        rx_byte;
    } item_t;

    // Request sequencer status toward the output stage
    typedef struct packed {
        logic       busy;
        logic [7:0] data;
        logic       last;
    } tx_out_t;

    // Completion produced by the response checker
    typedef struct packed {
        logic                done;
        logic [STATUS_W-1:0] status;
        logic [31:0]         value;
    } rx_done_t;

    // CRC-16/MODBUS over one byte, reflected
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/mrrt_in_reg.sv
// Input holding register: unpacks the slave stream into one item and holds it until used.
module mrrt_in_reg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mrrt_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [mrrt_pkg::KIND_W-1:0]   s_tuser,
    input  logic                          pop,
    output logic                          item_valid,
    output mrrt_pkg::item_t               item
);
    import mrrt_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    // Take a new transfer when empty or when the held item leaves this cycle
    assign s_tready = !valid_reg || pop;

    // Field unpack, lowest bits first
    always_comb begin
        item_next.kind          = s_tuser;
        item_next.slave_id      = s_tdata[7:0];
        item_next.function_code = s_tdata[15:8];
        item_next.start_address = s_tdata[31:16];
        item_next.quantity      = s_tdata[38:32];
        item_next.want_float    = s_tdata[39];
        item_next.rx_byte       = s_tdata[47:40];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (pop) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/mrrt_tx_seq.sv
// Request sequencer: steps through request bytes 1..7, folding bytes 1..5 into the CRC.
module mrrt_tx_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  mrrt_pkg::item_t   item,
    input  logic              advance,
    output mrrt_pkg::tx_out_t tx
);
    import mrrt_pkg::*;

    logic             busy_reg;
    logic [2:0]       idx_reg;
    logic [7:0]       func_reg;
    logic [15:0]      addr_reg;
    logic [QTY_W-1:0] qty_reg;
    logic [15:0]      crc_reg;
    logic [QTY_W-1:0] qty_clamped;
    logic [7:0]       cur_byte;

    assign qty_clamped = (item.quantity > MAX_QUANTITY) ? MAX_QUANTITY : item.quantity;

    // Byte at the current position
    always_comb begin
        unique case (idx_reg)
            REQ_FUNC:    cur_byte = func_reg;
            REQ_ADDR_HI: cur_byte = addr_reg[15:8];
            REQ_ADDR_LO: cur_byte = addr_reg[7:0];
            REQ_QTY_HI:  cur_byte = 8'h00;
            REQ_QTY_LO:  cur_byte = {1'b0, qty_reg};
            REQ_CRC_LO:  cur_byte = crc_reg[7:0];
            REQ_CRC_HI:  cur_byte = crc_reg[15:8];
            default:     cur_byte = 8'h00;
        endcase
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= REQ_FUNC;
        end else if (start) begin
            busy_reg <= 1'b1;
            idx_reg  <= REQ_FUNC;
        end else if (advance && busy_reg) begin
            if (idx_reg == REQ_CRC_HI) begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 3'd1;
        end
    end

    // Request fields and running CRC; slave id is folded in at start
    always_ff @(posedge aclk) begin
        if (start) begin
            func_reg <= item.function_code;
            addr_reg <= item.start_address;
            qty_reg  <= qty_clamped;
            crc_reg  <= crc_byte(CRC_INIT, item.slave_id);
        end else if (advance && busy_reg && idx_reg <= REQ_QTY_LO) begin
            crc_reg <= crc_byte(crc_reg, cur_byte);
        end
    end

    assign tx.busy = busy_reg;
    assign tx.data = cur_byte;
    assign tx.last = (idx_reg == REQ_CRC_HI);

endmodule

// File: rtl/mrrt_rx_check.sv
// Response checker: counts response bytes, runs the CRC, captures the value, reports completion.
module mrrt_rx_check (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  mrrt_pkg::item_t    item,
    output mrrt_pkg::rx_done_t done
);
    import mrrt_pkg::*;

    logic        waiting_reg;
    logic [7:0]  exp_len_reg;
    logic [7:0]  seen_reg;
    logic [15:0] crc_reg;
    logic [7:0]  held_reg [2];
    logic        float_reg;
    logic [31:0] word_reg;

    logic [QTY_W-1:0] qty_clamped;
    logic [7:0]       body;
    logic             in_body;
    logic             held_sel;
    logic [31:0]      word_next;
    logic [15:0]      crc_next;
    logic [7:0]       held_lo;
    logic [7:0]       held_hi;
    logic             last_byte;
    logic             is_rx;
    logic             is_abort;
    logic             is_start;

    assign is_start  = step && (item.kind == KIND_START);
    assign is_rx     = step && waiting_reg && (item.kind == KIND_RX);
    assign is_abort  = step && waiting_reg && (item.kind == KIND_ABORT);

    assign qty_clamped = (item.quantity > MAX_QUANTITY) ? MAX_QUANTITY : item.quantity;

    // Byte position within the response
    assign body      = exp_len_reg - 8'd2;
    assign in_body   = seen_reg < body;
    assign held_sel  = seen_reg[0] ^ body[0];
    assign last_byte = ({1'b0, seen_reg} + 9'd1) >= {1'b0, exp_len_reg};

    // Value capture, bytes 3..6 big-endian
    always_comb begin
        word_next = word_reg;
        unique case (seen_reg)
            8'd3:    word_next[31:24] = item.rx_byte;
            8'd4:    word_next[23:16] = item.rx_byte;
            8'd5:    word_next[15:8]  = item.rx_byte;
            8'd6:    word_next[7:0]   = item.rx_byte;
            default: word_next = word_reg;
        endcase
    end

    assign crc_next = in_body ? crc_byte(crc_reg, item.rx_byte) : crc_reg;
    assign held_lo  = (!in_body && !held_sel) ? item.rx_byte : held_reg[0];
    assign held_hi  = (!in_body &&  held_sel) ? item.rx_byte : held_reg[1];

    // Completion result
    always_comb begin
        done.done   = is_abort || (is_rx && last_byte);
        done.status = ST_OK;
        done.value  = 32'h0;
        if (is_abort) begin
            done.status = ST_TIMEOUT;
        end else if ({held_hi, held_lo} != crc_next) begin
            done.status = ST_CRC_ERR;
        end else if (float_reg) begin
            done.value = word_next;
        end else begin
            done.value = {16'h0000, word_next[31:16]};
        end
    end

    // Transaction state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            waiting_reg <= 1'b0;
        end else if (is_start) begin
            waiting_reg <= 1'b1;
        end else if (done.done) begin
            waiting_reg <= 1'b0;
        end
    end

    // Per-transaction payload
    always_ff @(posedge aclk) begin
        if (is_start) begin
            exp_len_reg <= HDR_LEN + {qty_clamped, 1'b0};
            seen_reg    <= 8'd0;
            crc_reg     <= CRC_INIT;
            held_reg[0] <= 8'h00;
            held_reg[1] <= 8'h00;
            word_reg    <= 32'h0;
            float_reg   <= item.want_float;
        end else if (is_rx) begin
            seen_reg    <= seen_reg + 8'd1;
            crc_reg     <= crc_next;
            held_reg[0] <= held_lo;
            held_reg[1] <= held_hi;
            word_reg    <= word_next;
        end
    end

endmodule

// File: rtl/modbus_rtu_read_transaction.sv
// Top level of the Modbus RTU read transaction: input register, sequencer, checker, output register.
//
// Usage:
//   Slave stream (s_*): one transfer per event. s_tuser is the kind: start a
//   read, a received response byte, or a receive timeout. A start carries the
//   slave id, function code, start address, register count and value format.
//   Master stream (m_*): m_tuser 0 is a request byte for the line (m_tlast on
//   the eighth byte, CRC high byte); m_tuser 1 is a completion with status
//   and value. Bytes and timeouts arriving with no transaction open produce
//   nothing; a start during an open transaction drops it silently.
// Timing: a start shows its first request byte in the cycle after it leaves the
//   input register, then one byte per cycle while m_tready is high; a final
//   response byte or a timeout shows its completion in the cycle after it
//   leaves the input register. Throughput: one received byte per cycle while
//   m_tready is high; a start occupies the request sequencer until its last
//   request byte is loaded, and no further item leaves the input register meanwhile.
// Reset: aresetn low clears both streams and closes any open transaction.
// Stall: with m_tready low the output register holds its transfer, the input
//   register fills, and s_tready falls once it is full.
module modbus_rtu_read_transaction (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Slave stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] slave_id, [15:8] function_code, [31:16] start_address,
    // [38:32] quantity, [39] want_float, [47:40] rx_byte
    input  logic [mrrt_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] kind
    input  logic [mrrt_pkg::KIND_W-1:0]   s_tuser,
    // Master stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] tx_byte, [9:8] status, [41:10] value, [47:42] zero
    output logic [mrrt_pkg::M_DATA_W-1:0] m_tdata,
    // [0] out_kind
    output logic                          m_tuser,
    // tx_last
    output logic                          m_tlast
);
    import mrrt_pkg::*;

    logic     item_valid;
    item_t    item;
    tx_out_t  tx;
    rx_done_t rx_done;
    logic     out_load;
    logic     pick;
    logic     start;

    logic                m_valid_reg;
    logic                m_valid_next;
    logic                m_kind_reg;
    logic                m_kind_next;
    logic [7:0]          m_byte_reg;
    logic [7:0]          m_byte_next;
    logic                m_last_reg;
    logic                m_last_next;
    logic [STATUS_W-1:0] m_status_reg;
    logic [STATUS_W-1:0] m_status_next;
    logic [31:0]         m_value_reg;
    logic [31:0]         m_value_next;

    // Output register free for a new transfer
    assign out_load = !m_valid_reg || m_tready;
    // Item leaves the input register when the sequencer is idle and output is free
    assign pick     = item_valid && out_load && !tx.busy;
    assign start    = pick && (item.kind == KIND_START);

    mrrt_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .pop        (pick),
        .item_valid (item_valid),
        .item       (item)
    );

    mrrt_tx_seq u_tx_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .item    (item),
        .advance (out_load),
        .tx      (tx)
    );

    mrrt_rx_check u_rx_check (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (pick),
        .item    (item),
        .done    (rx_done)
    );

    // Output select: sequencer bytes, then slave id on start, then completions
    always_comb begin
        m_valid_next  = 1'b0;
        m_kind_next   = OUT_TX;
        m_byte_next   = 8'h00;
        m_last_next   = 1'b0;
        m_status_next = ST_OK;
        m_value_next  = 32'h0;
        priority if (tx.busy) begin
            m_valid_next = 1'b1;
            m_byte_next  = tx.data;
            m_last_next  = tx.last;
        end else if (start) begin
            m_valid_next = 1'b1;
            m_byte_next  = item.slave_id;
        end else if (rx_done.done) begin
            m_valid_next  = 1'b1;
            m_kind_next   = OUT_DONE;
            m_status_next = rx_done.status;
            m_value_next  = rx_done.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload, no reset
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_kind_reg   <= m_kind_next;
            m_byte_reg   <= m_byte_next;
            m_last_reg   <= m_last_next;
            m_status_reg <= m_status_next;
            m_value_reg  <= m_value_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {6'b000000, m_value_reg, m_status_reg, m_byte_reg};

    // No item leaves the input register while request bytes are pending
    a_no_pick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        tx.busy |-> !pick)
        else $error("item consumed while request sequencer busy");

    // A start keeps the sequencer busy for the following bytes
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> tx.busy)
        else $error("sequencer not busy after start");

    // Only request bytes carry tlast
    a_last_tx_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (m_kind_reg == OUT_TX))
        else $error("tlast on a completion transfer");

    // Failed completions carry a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == OUT_DONE && m_status_reg != ST_OK)
            |-> (m_value_reg == 32'h0))
        else $error("nonzero value on failed completion");

endmodule

// File: tb/tb_modbus_rtu_read_transaction.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Modbus RTU read transaction block: directed table, then random transactions.
module tb_modbus_rtu_read_transaction;
    import mrrt_pkg::*;

    // Kind code the block has no use for
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int ITEM_TARGET  = 320;
    localparam int QUIET_AFTER  = 280;
    localparam int LONG_HOLD    = 150;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 20;

    typedef struct packed {
        logic                out_kind;
        logic [7:0]          tx_byte;
        logic                tx_last;
        logic [STATUS_W-1:0] status;
        logic [31:0]         value;
    } result_t;

    // One directed step; typed < 0 means the transaction model decides
    typedef struct {
        item_t   it;
        int      typed;
        result_t res;
    } row_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]   s_tuser  = KIND_START;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    // Transaction model state
    logic        txn_open   = 1'b0;
    logic [7:0]  resp_len   = '0;
    logic [7:0]  resp_count = '0;
    logic [15:0] chk_crc    = CRC_INIT;
    logic [7:0]  crc_hold [2] = '{8'h00, 8'h00};
    logic [31:0] word_acc   = '0;
    logic        float_view = 1'b0;

    result_t    predicted [$];
    result_t    awaited [$];
    logic [7:0] frame [$];
    int         errors     = 0;
    int         items_done = 0;
    int         idle_count = 0;
    bit         quiet      = 1'b0;
    bit         hold_req   = 1'b0;

    modbus_rtu_read_transaction DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // CRC-16/MODBUS, shifting in one data bit at a time
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ data[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic result_t mk_result(logic k, logic [7:0] b, logic l,
                                          logic [STATUS_W-1:0] s, logic [31:0] v);
        result_t r;
        r.out_kind = k;
        r.tx_byte  = b;
        r.tx_last  = l;
        r.status   = s;
        r.value    = v;
        return r;
    endfunction

    // Item of the given kind with every field random
    function automatic item_t mk_item(logic [KIND_W-1:0] k);
        item_t it;
        it.kind          = k;
        it.slave_id      = 8'($urandom);
        it.function_code = 8'($urandom);
        it.start_address = 16'($urandom);
        it.quantity      = 7'($urandom);
        it.want_float    = 1'($urandom);
        it.rx_byte       = 8'($urandom);
        return it;
    endfunction

    function automatic item_t mk_start(logic [7:0] sid, logic [7:0] fc, logic [15:0] addr,
                                       logic [QTY_W-1:0] q, logic flt);
        item_t it;
        it               = mk_item(KIND_START);
        it.slave_id      = sid;
        it.function_code = fc;
        it.start_address = addr;
        it.quantity      = q;
        it.want_float    = flt;
        return it;
    endfunction

    function automatic item_t mk_rx(logic [7:0] b);
        item_t it;
        it         = mk_item(KIND_RX);
        it.rx_byte = b;
        return it;
    endfunction

    function automatic row_t mk_row(item_t it, int typed, result_t res);
        row_t r;
        r.it    = it;
        r.typed = typed;
        r.res   = res;
        return r;
    endfunction

    // Response frame: header, register data, CRC low byte first; optionally one bit flipped
    function automatic void build_frame(logic [7:0] sid, logic [7:0] fc, logic [QTY_W-1:0] q,
                                        bit alt, bit corrupt);
        logic [15:0] c;
        int          pos;
        frame.delete();
        frame.push_back(sid);
        frame.push_back(fc);
        frame.push_back({q, 1'b0});
        for (int i = 0; i < 2 * q; i++) begin
            frame.push_back(alt ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom));
        end
        c = CRC_INIT;
        foreach (frame[i]) begin
            c = crc16_update(c, frame[i]);
        end
        frame.push_back(c[7:0]);
        frame.push_back(c[15:8]);
        if (corrupt) begin
            pos = $urandom_range(0, frame.size() - 1);
            frame[pos] ^= 8'(1 << $urandom_range(0, 7));
        end
    endfunction

    // Transaction model: fills predicted, returns 1 unless the item is ignored
    function automatic bit model_step(item_t it);
        logic [7:0]       req [8];
        logic [QTY_W-1:0] q;
        logic [15:0]      c;
        logic [7:0]       body;
        int               idx;
        predicted.delete();
        if (it.kind == KIND_START) begin
            q      = (it.quantity > MAX_QUANTITY) ? MAX_QUANTITY : it.quantity;
            req[0] = it.slave_id;
            req[1] = it.function_code;
            req[2] = it.start_address[15:8];
            req[3] = it.start_address[7:0];
            req[4] = 8'h00;
            req[5] = {1'b0, q};
            c = CRC_INIT;
            for (int i = 0; i < 6; i++) begin
                c = crc16_update(c, req[i]);
            end
            req[6] = c[7:0];
            req[7] = c[15:8];
            for (int i = 0; i < 8; i++) begin
                predicted.push_back(mk_result(OUT_TX, req[i], i == 7, ST_OK, 32'h0));
            end
            txn_open    = 1'b1;
            resp_len    = HDR_LEN + {q, 1'b0};
            resp_count  = '0;
            chk_crc     = CRC_INIT;
            crc_hold[0] = 8'h00;
            crc_hold[1] = 8'h00;
            word_acc    = '0;
            float_view  = it.want_float;
            return 1'b1;
        end
        if (!txn_open || it.kind == KIND_UNUSED) begin
            return 1'b0;
        end
        if (it.kind == KIND_ABORT) begin
            txn_open = 1'b0;
            predicted.push_back(mk_result(OUT_DONE, 8'h00, 1'b0, ST_TIMEOUT, 32'h0));
            return 1'b1;
        end
        // received byte: bytes 3..6 build the value, the last two carry the CRC
        idx  = resp_count;
        body = resp_len - 8'd2;
        if (idx >= 3 && idx <= 6) begin
            word_acc |= 32'(it.rx_byte) << ((6 - idx) * 8);
        end
        if (idx < body) begin
            chk_crc = crc16_update(chk_crc, it.rx_byte);
        end else begin
            crc_hold[(idx - body) & 1] = it.rx_byte;
        end
        resp_count = resp_count + 8'd1;
        if (resp_count >= resp_len) begin
            txn_open = 1'b0;
            if ({crc_hold[1], crc_hold[0]} == chk_crc) begin
                predicted.push_back(mk_result(OUT_DONE, 8'h00, 1'b0, ST_OK,
                                    float_view ? word_acc : {16'h0, word_acc[31:16]}));
            end else begin
                predicted.push_back(mk_result(OUT_DONE, 8'h00, 1'b0, ST_CRC_ERR, 32'h0));
            end
        end
        return 1'b1;
    endfunction

    // Offer one item, wait for the transfer, then queue what it should produce
    task automatic send_item(input item_t it, input int typed = -1, input result_t fixed_res = '0);
        bit acted;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {it.rx_byte, it.want_float, it.quantity, it.start_address,
                     it.function_code, it.slave_id};
        do @(posedge aclk); while (!s_tready);
        acted = model_step(it);
        if (typed < 0) begin
            foreach (predicted[i]) begin
                awaited.push_back(predicted[i]);
            end
        end else if (typed > 0) begin
            awaited.push_back(fixed_res);
        end
        if (acted) begin
            items_done++;
        end
    endtask

    // Stop offering and let every pending result come out
    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (awaited.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Result side: random stall bursts, one long hold on request
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = LONG_HOLD;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 6);
            end else begin
                stall = 0;
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    // Compare each result transfer with the oldest pending one
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tuser %b tdata %h",
                         $time, m_tuser, m_tdata);
                errors++;
            end else begin
                want = awaited.pop_front();
                check_field("out_kind", 32'(want.out_kind), 32'(m_tuser));
                check_field("tx_byte", 32'(want.tx_byte), 32'(m_tdata[7:0]));
                check_field("tx_last", 32'(want.tx_last), 32'(m_tlast));
                check_field("status", 32'(want.status), 32'(m_tdata[9:8]));
                check_field("value", want.value, m_tdata[41:10]);
                check_field("tdata padding", 32'h0, 32'(m_tdata[47:42]));
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_count = 0;
            end else begin
                idle_count++;
            end
            if (idle_count >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        row_t             plan [$];
        item_t            it;
        logic [QTY_W-1:0] q;
        logic [QTY_W-1:0] qe;
        int               fate;
        int               cut;
        bit               hold_done;
        bit               drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: ignored items while idle, including the unused kind with all bits set
        plan.push_back(mk_row(mk_rx(8'hFF), 0, '0));
        plan.push_back(mk_row(mk_item(KIND_ABORT), 0, '0));
        it = '1;
        plan.push_back(mk_row(it, 0, '0));
        // all-ones request, quantity clamped, then a timeout
        plan.push_back(mk_row(mk_start(8'hFF, 8'hFF, 16'hFFFF, 7'd127, 1'b1), -1, '0));
        plan.push_back(mk_row(mk_item(KIND_ABORT), 1,
                       mk_result(OUT_DONE, 8'h00, 1'b0, ST_TIMEOUT, 32'h0)));
        // all-zero request with quantity zero, float view, good frame
        plan.push_back(mk_row(mk_start(8'h00, 8'h00, 16'h0000, 7'd0, 1'b1), -1, '0));
        build_frame(8'h00, 8'h00, 7'd0, 1'b0, 1'b0);
        foreach (frame[i]) begin
            plan.push_back(mk_row(mk_rx(frame[i]), -1, '0));
        end
        // a start while waiting drops the first transaction
        plan.push_back(mk_row(mk_start(8'h01, 8'h03, 16'h1234, 7'd1, 1'b0), -1, '0));
        plan.push_back(mk_row(mk_start(8'h11, 8'h04, 16'h8001, 7'd2, 1'b1), -1, '0));
        // damaged frame ends in a CRC error
        build_frame(8'h11, 8'h04, 7'd2, 1'b1, 1'b1);
        for (int i = 0; i < frame.size() - 1; i++) begin
            plan.push_back(mk_row(mk_rx(frame[i]), -1, '0));
        end
        plan.push_back(mk_row(mk_rx(frame[frame.size() - 1]), 1,
                       mk_result(OUT_DONE, 8'h00, 1'b0, ST_CRC_ERR, 32'h0)));
        // byte after completion is ignored
        plan.push_back(mk_row(mk_rx(8'h00), 0, '0));

        foreach (plan[i]) begin
            send_item(plan[i].it, plan[i].typed, plan[i].res);
        end
        wait_for_results();

        // Random transactions: mostly good frames, some damaged, cut short or restarted
        while (items_done < ITEM_TARGET) begin
            if (items_done >= QUIET_AFTER) begin
                quiet = 1'b1;
            end
            if (!drain_done && items_done >= 200) begin
                drain_done = 1'b1;
                wait_for_results();
            end
            if ($urandom_range(0, 9) == 0) begin
                // stray traffic between transactions
                repeat ($urandom_range(1, 3)) begin
                    it = mk_item(KIND_RX);
                    case ($urandom_range(0, 2))
                        1: begin
                            it.kind = KIND_ABORT;
                        end
                        2: begin
                            it.kind = KIND_UNUSED;
                        end
                        default: begin
                        end
                    endcase
                    send_item(it);
                end
                continue;
            end
            // long result-side hold right before a request so the block backs up
            if (!hold_done && items_done >= 100) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            q  = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, 4));
            qe = (q > MAX_QUANTITY) ? MAX_QUANTITY : q;
            it = mk_start(8'($urandom), 8'($urandom), 16'($urandom), q, 1'($urandom));
            send_item(it);
            fate = $urandom_range(0, 99);
            build_frame(it.slave_id, it.function_code, qe, 1'b0, fate >= 75 && fate < 87);
            cut = (fate >= 87) ? $urandom_range(0, frame.size() - 1) : frame.size();
            for (int i = 0; i < cut; i++) begin
                if ($urandom_range(0, 29) == 0) begin
                    send_item(mk_item(KIND_UNUSED));
                end
                send_item(mk_rx(frame[i]));
            end
            if (fate >= 87 && fate < 94) begin
                send_item(mk_item(KIND_ABORT));
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0 && awaited.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
